// ===== src/ssrl_pkg.sv =====
`default_nettype none

package ssrl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_WIDTH  = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // fixed port widths
  localparam int PORT_ADDR_W  = 64;
  localparam int PORT_INDEX_W = 10;
  localparam int COUNT_REG_W  = 11;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;

  // action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SYMBOL_COUNT = 2'd0,
    CFG_SECTION_END  = 2'd1
  } cfg_reg_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SRCH,
    ST_SRCH_CHK,
    ST_BACK,
    ST_BACK_CHK,
    ST_FWD,
    ST_FWD_CHK,
    ST_FIN
  } state_t;

  // table read address source
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_MID,
    RD_LO_M1,
    RD_K
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    wr_en;
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    take_first;
    logic    srch_upd;
    logic    back_step;
    logic    fwd_init;
    logic    fwd_step;
    logic    set_end;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic srch_more;
    logic back_more;
    logic alias_eq;
    logic fwd_more;
    logic fwd_hit;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/ssrl_ctrl.sv =====
`default_nettype none

module ssrl_ctrl
  import ssrl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_action,
  input  wire status_t status,
  output logic         in_stall,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_LOOKUP) state_nxt = ST_FIRST;
      end
      ST_FIRST: state_nxt = ST_SRCH;
      ST_SRCH: begin
        state_nxt = status.srch_more ? ST_SRCH_CHK : ST_BACK;
      end
      ST_SRCH_CHK: state_nxt = ST_SRCH;
      ST_BACK: begin
        state_nxt = status.back_more ? ST_BACK_CHK : ST_FWD;
      end
      ST_BACK_CHK: begin
        state_nxt = status.alias_eq ? ST_BACK : ST_FWD;
      end
      ST_FWD: begin
        state_nxt = status.fwd_more ? ST_FWD_CHK : ST_FIN;
      end
      ST_FWD_CHK: begin
        state_nxt = status.fwd_hit ? ST_FIN : ST_FWD;
      end
      ST_FIN: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == ACT_LOOKUP) begin
            cmd.load   = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ZERO;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_FIRST: cmd.take_first = 1'b1;
      ST_SRCH: begin
        if (status.srch_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
        end
      end
      ST_SRCH_CHK: cmd.srch_upd = 1'b1;
      ST_BACK: begin
        if (status.back_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LO_M1;
        end else begin
          cmd.fwd_init = 1'b1;
        end
      end
      ST_BACK_CHK: begin
        if (status.alias_eq) cmd.back_step = 1'b1;
        else                 cmd.fwd_init  = 1'b1;
      end
      ST_FWD: begin
        if (status.fwd_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_K;
        end
      end
      ST_FWD_CHK: begin
        if (status.fwd_hit) cmd.set_end  = 1'b1;
        else                cmd.fwd_step = 1'b1;
      end
      ST_FIN: begin
        if (status.out_free) cmd.out_load = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/ssrl_datapath.sv =====
`default_nettype none

module ssrl_datapath
  import ssrl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output status_t                      status,
  input  wire logic [PORT_INDEX_W-1:0] in_entry_index,
  input  wire logic [PORT_ADDR_W-1:0]  in_entry_address,
  input  wire logic [PORT_ADDR_W-1:0]  in_query_address,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [PORT_INDEX_W-1:0]      out_match_index,
  output logic [PORT_ADDR_W-1:0]       out_symbol_length,
  output logic [PORT_ADDR_W-1:0]       out_offset_in_symbol,
  output logic                         out_below_first
);

  logic [ADDR_WIDTH-1:0]  mem [TABLE_DEPTH];
  logic [ADDR_WIDTH-1:0]  rd_data_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_ok;

  logic [COUNT_REG_W-1:0] count_r;
  logic [ADDR_WIDTH-1:0]  section_end_r;
  logic [CNT_W-1:0]       n_active;

  logic [ADDR_WIDTH-1:0]  q_r, first_r, start_r, end_r;
  logic [CNT_W-1:0]       lo_r, hi_r, k_r, mid;

  logic                   out_valid_r;
  logic [PORT_INDEX_W-1:0] match_r;
  logic [PORT_ADDR_W-1:0] length_r, offset_r;
  logic                   below_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= COUNT_REG_W'(1);
      section_end_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYMBOL_COUNT: count_r       <= cfg_data[COUNT_REG_W-1:0];
        CFG_SECTION_END:  section_end_r <= cfg_data[ADDR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // clamp count to 1..depth
  always_comb begin
    if (count_r == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(count_r) > 32'(TABLE_DEPTH)) begin
      n_active = CNT_W'(TABLE_DEPTH);
    end else begin
      n_active = CNT_W'(count_r);
    end
  end

  // search midpoint and read address
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO:  rd_addr = '0;
      RD_MID:   rd_addr = IDX_W'(mid);
      RD_LO_M1: rd_addr = IDX_W'(lo_r - CNT_W'(1));
      RD_K:     rd_addr = IDX_W'(k_r);
      default:  rd_addr = '0;
    endcase
  end

  assign wr_ok = 32'(in_entry_index) < 32'(TABLE_DEPTH);

  // address table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[IDX_W'(in_entry_index)] <= in_entry_address[ADDR_WIDTH-1:0];
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // search, alias and successor registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r  <= in_query_address[ADDR_WIDTH-1:0];
      lo_r <= '0;
      hi_r <= n_active;
    end
    if (cmd.take_first) begin
      first_r <= rd_data_r;
      start_r <= rd_data_r;
    end
    if (cmd.srch_upd) begin
      if (rd_data_r <= q_r) begin
        lo_r    <= mid;
        start_r <= rd_data_r;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.back_step) begin
      lo_r <= lo_r - CNT_W'(1);
    end
    if (cmd.fwd_init) begin
      k_r   <= lo_r + CNT_W'(1);
      end_r <= section_end_r;
    end
    if (cmd.fwd_step) begin
      k_r <= k_r + CNT_W'(1);
    end
    if (cmd.set_end) begin
      end_r <= rd_data_r;
    end
  end

  // status to controller
  assign status.srch_more = (hi_r - lo_r) > CNT_W'(1);
  assign status.back_more = lo_r != '0;
  assign status.alias_eq  = rd_data_r == start_r;
  assign status.fwd_more  = k_r < n_active;
  assign status.fwd_hit   = rd_data_r > start_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      match_r  <= PORT_INDEX_W'(lo_r);
      length_r <= PORT_ADDR_W'(end_r - start_r);
      offset_r <= PORT_ADDR_W'(q_r - start_r);
      below_r  <= q_r < first_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_match_index      = match_r;
  assign out_symbol_length    = length_r;
  assign out_offset_in_symbol = offset_r;
  assign out_below_first      = below_r;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending word");

  // probe stays strictly inside the open search window
  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.rd_sel == RD_MID) |-> (mid > lo_r && mid < hi_r))
    else $error("search probe outside window");

  // successor scan stays inside the active entries
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.rd_sel == RD_K) |-> (k_r < n_active && k_r > lo_r))
    else $error("successor scan out of range");

endmodule

`default_nettype wire

// ===== src/sorted_symbol_range_lookup.sv =====
`default_nettype none

// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | action, entry_index, entry_address, query_address
// out     | output    | out_valid/out_stall | match_index, symbol_length, offset_in_symbol,
//         |           |                     | below_first
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// write word: taken while idle with in_stall low, straight into the table
// lookup: in_stall high from ST_FIRST until ST_FIN hands off; p probes (at most ceil(log2 n)),
//   a alias reads and s successor reads, one read port with a registered output;
//   the step-back may end at entry 0, and when no greater entry follows the section end is used
// synchronous active-low reset clears control and sets config (count 1, section end 0); table is not cleared
// a done lookup waits for the output register to free up; a result waiting under
//   out_stall does not hold back the next word

module sorted_symbol_range_lookup
  import ssrl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_action,
  input  wire logic [PORT_INDEX_W-1:0] in_entry_index,
  input  wire logic [PORT_ADDR_W-1:0]  in_entry_address,
  input  wire logic [PORT_ADDR_W-1:0]  in_query_address,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [PORT_INDEX_W-1:0]      out_match_index,
  output logic [PORT_ADDR_W-1:0]       out_symbol_length,
  output logic [PORT_ADDR_W-1:0]       out_offset_in_symbol,
  output logic                         out_below_first,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  ssrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // table, search registers and result
  ssrl_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_entry_index       (in_entry_index),
    .in_entry_address     (in_entry_address),
    .in_query_address     (in_query_address),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_match_index      (out_match_index),
    .out_symbol_length    (out_symbol_length),
    .out_offset_in_symbol (out_offset_in_symbol),
    .out_below_first      (out_below_first)
  );

endmodule

`default_nettype wire
